@@ rtl/core/b2s_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// b2s_pkg
// Shared types, constants and tables of the BLAKE2s-256 hash core.
// ----------------------------------------------------------------------------
package b2s_pkg;

  localparam int WordW     = 32;
  localparam int BlockWords = 16;
  localparam int Rounds    = 10;
  localparam int DigestWords = 8;
  localparam logic [31:0] ParamWord = 32'h0101_0020;
  localparam logic [63:0] BlockByteCount = 64'd64;

  typedef logic [31:0] word_t;

  // datapath commands from the controller
  typedef struct packed {
    logic load;      // store incoming word
    logic init;      // load work vector
    logic final_blk; // with final flag
    logic step;      // one G step
    logic finish;    // fold work vector into chain value
    logic add_full;  // counter += 64
    logic add_tail;  // counter += held bytes plus this item's bytes
    logic clear;     // clear buffer
    logic reinit;    // chain/counter back to initial
  } b2s_cmd_t;

  typedef struct packed {
    logic buf_full;
  } b2s_stat_t;

  function automatic word_t iv(input logic [2:0] i);
    word_t r;
    unique case (i)
      3'd0: r = 32'h6A09E667;
      3'd1: r = 32'hBB67AE85;
      3'd2: r = 32'h3C6EF372;
      3'd3: r = 32'hA54FF53A;
      3'd4: r = 32'h510E527F;
      3'd5: r = 32'h9B05688C;
      3'd6: r = 32'h1F83D9AB;
      default: r = 32'h5BE0CD19;
    endcase
    return r;
  endfunction

  localparam logic [3:0] Sigma [10][16] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
      4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
    '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
      4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
    '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
      4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
    '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
      4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
    '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
      4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
    '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
      4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
    '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
      4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
    '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
      4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
    '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
      4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
  };

endpackage
`default_nettype wire

@@ rtl/core/b2s_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// b2s_in_if / b2s_out_if
// Valid/ready channels for message words and digest words.
// ----------------------------------------------------------------------------
interface b2s_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic [2:0]  word_bytes;
  logic        last_word;
  modport source (output valid, message_word, word_bytes, last_word, input ready);
  modport sink (input valid, message_word, word_bytes, last_word, output ready);
endinterface

interface b2s_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        digest_last;
  modport source (output valid, digest_word, digest_last, input ready);
  modport sink (input valid, digest_word, digest_last, output ready);
endinterface
`default_nettype wire

@@ rtl/core/b2s_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// b2s_datapath
// Block buffer, chain value, byte counter and a G unit that runs one
// full G function (two message words) per step.
// ----------------------------------------------------------------------------
module b2s_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire b2s_pkg::b2s_cmd_t   cmd,
  input  wire logic [31:0]         in_word,
  input  wire logic [2:0]          in_bytes,
  input  wire logic                in_last,
  input  wire logic [3:0]          round,
  input  wire logic [2:0]          g_sel,
  input  wire logic [2:0]          out_sel,
  output b2s_pkg::b2s_stat_t       stat,
  output logic [31:0]              digest
);

  logic [31:0] chain [8];
  logic [63:0] counter;
  logic [31:0] buffer [16];
  logic [4:0]  word_index;
  logic [6:0]  block_bytes;
  logic [31:0] v [16];

  logic [2:0]  nb;
  logic [31:0] masked;
  assign nb = !in_last ? 3'd4 : (in_bytes > 3'd4 ? 3'd4 : in_bytes);
  always_comb begin
    unique case (nb)
      3'd1: masked = {24'd0, in_word[7:0]};
      3'd2: masked = {16'd0, in_word[15:0]};
      3'd3: masked = {8'd0, in_word[23:0]};
      default: masked = in_word;
    endcase
  end

  assign stat.buf_full = word_index[4];

  // G operand indexes
  logic [3:0] ia, ib, ic, id;
  always_comb begin
    unique case (g_sel)
      3'd0: begin ia = 4'd0; ib = 4'd4; ic = 4'd8;  id = 4'd12; end
      3'd1: begin ia = 4'd1; ib = 4'd5; ic = 4'd9;  id = 4'd13; end
      3'd2: begin ia = 4'd2; ib = 4'd6; ic = 4'd10; id = 4'd14; end
      3'd3: begin ia = 4'd3; ib = 4'd7; ic = 4'd11; id = 4'd15; end
      3'd4: begin ia = 4'd0; ib = 4'd5; ic = 4'd10; id = 4'd15; end
      3'd5: begin ia = 4'd1; ib = 4'd6; ic = 4'd11; id = 4'd12; end
      3'd6: begin ia = 4'd2; ib = 4'd7; ic = 4'd8;  id = 4'd13; end
      default: begin ia = 4'd3; ib = 4'd4; ic = 4'd9; id = 4'd14; end
    endcase
  end

  logic [31:0] mx, my, a1, d1, c1, b1, a2, d2, c2, b2;
  always_comb begin
    mx = buffer[b2s_pkg::Sigma[round][{g_sel, 1'b0}]];
    my = buffer[b2s_pkg::Sigma[round][{g_sel, 1'b1}]];
    a1 = v[ia] + v[ib] + mx;
    d1 = v[id] ^ a1;  d1 = {d1[15:0], d1[31:16]};
    c1 = v[ic] + d1;
    b1 = v[ib] ^ c1;  b1 = {b1[11:0], b1[31:12]};
    a2 = a1 + b1 + my;
    d2 = d1 ^ a2;     d2 = {d2[7:0], d2[31:8]};
    c2 = c1 + d2;
    b2 = b1 ^ c2;     b2 = {b2[6:0], b2[31:7]};
  end

  assign digest = chain[out_sel];

  always_ff @(posedge clk) begin
    if (rst || cmd.reinit) begin
      for (int i = 0; i < 8; i++)
        chain[i] <= b2s_pkg::iv(3'(i)) ^ ((i == 0) ? b2s_pkg::ParamWord : 32'd0);
      counter <= '0;
    end else begin
      if (cmd.add_full) counter <= counter + b2s_pkg::BlockByteCount;
      else if (cmd.add_tail) counter <= counter + {57'd0, block_bytes} + {61'd0, nb};
      if (cmd.finish)
        for (int i = 0; i < 8; i++) chain[i] <= chain[i] ^ v[i] ^ v[i+8];
    end
    if (rst || cmd.clear) begin
      for (int i = 0; i < 16; i++) buffer[i] <= '0;
      word_index <= '0;
      block_bytes <= '0;
    end else if (cmd.load && nb != 3'd0) begin
      buffer[word_index[3:0]] <= masked;
      word_index <= word_index + 5'd1;
      block_bytes <= block_bytes + {4'd0, nb};
    end
    if (cmd.init) begin
      for (int i = 0; i < 8; i++) v[i] <= chain[i];
      for (int i = 0; i < 4; i++) v[i+8] <= b2s_pkg::iv(3'(i));
      v[12] <= b2s_pkg::iv(3'd4) ^ counter[31:0];
      v[13] <= b2s_pkg::iv(3'd5) ^ counter[63:32];
      v[14] <= b2s_pkg::iv(3'd6) ^ {32{cmd.final_blk}};
      v[15] <= b2s_pkg::iv(3'd7);
    end else if (cmd.step) begin
      v[ia] <= a2; v[ib] <= b2; v[ic] <= c2; v[id] <= d2;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/b2s_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// b2s_ctrl
// Sequencer: takes words, runs compressions, walks out the digest.
// ----------------------------------------------------------------------------
module b2s_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_bytes,
  input  wire logic               in_last,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_last,
  input  wire b2s_pkg::b2s_stat_t stat,
  output b2s_pkg::b2s_cmd_t       cmd,
  output logic [3:0]              round,
  output logic [2:0]              g_sel,
  output logic [2:0]              out_sel
);

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_RUN, S_FOLD, S_OUT
  } state_t;

  state_t state;
  logic   is_final;   // current compression is the final one
  logic   has_bytes;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_last  = (out_sel == 3'd7);
  assign has_bytes = in_last ? (in_bytes != 3'd0) : 1'b1;

  logic take, mid;
  assign take = in_valid && in_ready;
  // a word with bytes and a full buffer forces a non-final compression first
  assign mid = take && has_bytes && stat.buf_full;

  always_comb begin
    cmd = '0;
    cmd.load      = take && !mid;
    cmd.add_full  = mid;
    cmd.add_tail  = take && !mid && in_last;
    cmd.init      = (state == S_INIT);
    cmd.final_blk = is_final;
    cmd.step      = (state == S_RUN);
    cmd.finish    = (state == S_FOLD);
    // buffer is emptied after every compression, final one included
    cmd.clear     = (state == S_FOLD);
    cmd.reinit    = (state == S_OUT) && out_ready && out_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      is_final <= 1'b0;
      round <= '0;
      g_sel <= '0;
      out_sel <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (take) begin
            // a mid compression leaves the item unaccepted; it is retaken
            if (mid) begin
              is_final <= 1'b0;
              state <= S_INIT;
            end else if (in_last) begin
              is_final <= 1'b1;
              state <= S_INIT;
            end
          end
        end
        S_INIT: begin
          round <= '0;
          g_sel <= '0;
          state <= S_RUN;
        end
        S_RUN: begin
          g_sel <= g_sel + 3'd1;
          if (g_sel == 3'd7) begin
            round <= round + 4'd1;
            if (round == 4'(b2s_pkg::Rounds - 1)) state <= S_FOLD;
          end
        end
        S_FOLD: begin
          out_sel <= '0;
          state <= is_final ? S_OUT : S_IDLE;
        end
        S_OUT: begin
          if (out_ready) begin
            out_sel <= out_sel + 3'd1;
            if (out_last) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/blake2s_256_hash_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// blake2s_256_hash_core
// Unkeyed BLAKE2s-256: message words in, eight digest words out.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  msg      in   message_word[31:0] word_bytes[2:0] last_word
//  dig      out  digest_word[31:0] digest_last
//
// A word is taken while the core is idle. The word after a full block, and a
// last word, start a compression (load, 80 G steps on the shared G unit,
// fold); the word after a full block is taken when it ends.
// Digest words follow, one per cycle while dig.ready is high.
// Synchronous reset; no clearing pass. Input is held off during rounds and
// digest output.
module blake2s_256_hash_core (
  input  wire logic clk,
  input  wire logic rst,
  b2s_in_if.sink    msg,
  b2s_out_if.source dig
);

  b2s_pkg::b2s_cmd_t  cmd;
  b2s_pkg::b2s_stat_t stat;
  logic [3:0] round;
  logic [2:0] g_sel, out_sel;
  logic       in_ready_int;

  // on a mid compression the item is not accepted
  assign msg.ready = in_ready_int && !(msg.valid && stat.buf_full &&
                     !(msg.last_word && msg.word_bytes == 3'd0));

  b2s_ctrl u_ctrl (
    .clk, .rst,
    .in_valid (msg.valid), .in_ready (in_ready_int),
    .in_bytes (msg.word_bytes), .in_last (msg.last_word),
    .out_valid (dig.valid), .out_ready (dig.ready), .out_last (dig.digest_last),
    .stat, .cmd, .round, .g_sel, .out_sel
  );

  b2s_datapath u_dp (
    .clk, .rst, .cmd,
    .in_word (msg.message_word), .in_bytes (msg.word_bytes),
    .in_last (msg.last_word),
    .round, .g_sel, .out_sel, .stat,
    .digest (dig.digest_word)
  );

endmodule
`default_nettype wire

@@ rtl/core/b2s_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// b2s_checker
// Port-level checks of the hash core.
// ----------------------------------------------------------------------------
module b2s_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_last
);
  // no input taken while a digest is pending
  a_no_in_during_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken during digest");
  // digest stays up until last word leaves
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !(out_ready && out_last) |=> out_valid)
    else $error("digest dropped");
  // after final digest word, output goes idle
  a_out_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_last |=> !out_valid)
    else $error("extra digest word");
endmodule

bind blake2s_256_hash_core b2s_checker u_chk (
  .clk, .rst,
  .in_valid (msg.valid), .in_ready (msg.ready),
  .out_valid (dig.valid), .out_ready (dig.ready), .out_last (dig.digest_last)
);
`default_nettype wire

@@ tb/b2s_digest_checker.sv @@
// ----------------------------------------------------------------------------
// b2s_digest_checker
// Watches the message and digest channels, predicts the BLAKE2s-256 digest
// of each message and compares every digest word with the prediction.
// ----------------------------------------------------------------------------
module b2s_digest_checker (
  input  logic clk,
  input  logic rst,
  b2s_in_if    msg,
  b2s_out_if   dig,
  output int   fail_count,
  output int   digests_pending,
  output int   digest_words_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    b2s_pkg::word_t word;
    logic           last;
  } digest_item_t;

  localparam b2s_pkg::word_t InitVec [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  digest_item_t   digest_q[$];
  b2s_pkg::word_t chain [8];
  b2s_pkg::word_t blk [16];
  b2s_pkg::word_t work_v [16];
  logic [63:0]    byte_cnt;
  int             held_words;
  int             held_bytes;

  function automatic b2s_pkg::word_t rotr(b2s_pkg::word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic clear_block();
    for (int i = 0; i < 16; i++) blk[i] = '0;
    held_words = 0;
    held_bytes = 0;
  endtask

  task automatic init_chain();
    for (int i = 0; i < 8; i++) chain[i] = InitVec[i];
    chain[0] ^= 32'h0101_0020;
    byte_cnt = '0;
    clear_block();
  endtask

  task automatic quarter(int a, int b, int c, int d, b2s_pkg::word_t x,
                         b2s_pkg::word_t y);
    work_v[a] = work_v[a] + work_v[b] + x;
    work_v[d] = rotr(work_v[d] ^ work_v[a], 16);
    work_v[c] = work_v[c] + work_v[d];
    work_v[b] = rotr(work_v[b] ^ work_v[c], 12);
    work_v[a] = work_v[a] + work_v[b] + y;
    work_v[d] = rotr(work_v[d] ^ work_v[a], 8);
    work_v[c] = work_v[c] + work_v[d];
    work_v[b] = rotr(work_v[b] ^ work_v[c], 7);
  endtask

  task automatic compress(logic final_blk);
    for (int i = 0; i < 8; i++) begin
      work_v[i]     = chain[i];
      work_v[i + 8] = InitVec[i];
    end
    work_v[12] ^= byte_cnt[31:0];
    work_v[13] ^= byte_cnt[63:32];
    if (final_blk) work_v[14] = ~work_v[14];
    for (int r = 0; r < 10; r++) begin
      quarter(0, 4, 8, 12, blk[b2s_pkg::Sigma[r][0]], blk[b2s_pkg::Sigma[r][1]]);
      quarter(1, 5, 9, 13, blk[b2s_pkg::Sigma[r][2]], blk[b2s_pkg::Sigma[r][3]]);
      quarter(2, 6, 10, 14, blk[b2s_pkg::Sigma[r][4]], blk[b2s_pkg::Sigma[r][5]]);
      quarter(3, 7, 11, 15, blk[b2s_pkg::Sigma[r][6]], blk[b2s_pkg::Sigma[r][7]]);
      quarter(0, 5, 10, 15, blk[b2s_pkg::Sigma[r][8]], blk[b2s_pkg::Sigma[r][9]]);
      quarter(1, 6, 11, 12, blk[b2s_pkg::Sigma[r][10]], blk[b2s_pkg::Sigma[r][11]]);
      quarter(2, 7, 8, 13, blk[b2s_pkg::Sigma[r][12]], blk[b2s_pkg::Sigma[r][13]]);
      quarter(3, 4, 9, 14, blk[b2s_pkg::Sigma[r][14]], blk[b2s_pkg::Sigma[r][15]]);
    end
    for (int i = 0; i < 8; i++) chain[i] ^= work_v[i] ^ work_v[i + 8];
  endtask

  task automatic absorb_word(b2s_pkg::word_t w, logic [2:0] nb, logic lst);
    int n;
    n = !lst ? 4 : (nb > 3'd4 ? 4 : int'(nb));
    if (n > 0) begin
      if (held_words >= 16) begin
        byte_cnt += 64'd64;
        compress(1'b0);
        clear_block();
      end
      if (n < 4) w &= (32'd1 << (8 * n)) - 32'd1;
      blk[held_words[3:0]] = w;
      held_words++;
      held_bytes += n;
    end
    if (lst) begin
      byte_cnt += 64'(held_bytes);
      compress(1'b1);
      for (int k = 0; k < 8; k++) digest_q.push_back('{word: chain[k], last: (k == 7)});
      init_chain();
    end
  endtask

  task automatic report_mismatch(string what, b2s_pkg::word_t got, b2s_pkg::word_t want);
    $display("[%0t] digest mismatch: %s got %h expected %h", $time, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    digest_words_seen = 0;
    init_chain();
  end

  assign digests_pending = digest_q.size();

  always @(posedge clk) begin
    digest_item_t e;
    if (!rst) begin
      if (dig.valid && dig.ready) begin
        digest_words_seen++;
        if (digest_q.size() == 0) begin
          report_mismatch("unexpected item", dig.digest_word, '0);
        end else begin
          e = digest_q.pop_front();
          if (dig.digest_word !== e.word) report_mismatch("digest_word", dig.digest_word, e.word);
          if (dig.digest_last !== e.last)
            report_mismatch("digest_last", 32'(dig.digest_last), 32'(e.last));
        end
      end
      if (msg.valid && msg.ready) absorb_word(msg.message_word, msg.word_bytes, msg.last_word);
    end
  end
endmodule

@@ tb/blake2s_256_hash_core_tb.sv @@
// ----------------------------------------------------------------------------
// blake2s_256_hash_core_tb
// Feeds messages of many lengths and tail sizes into the hash core under
// several idle/stall mixes; the checker predicts and compares each digest.
// ----------------------------------------------------------------------------
module blake2s_256_hash_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 4000;

  logic clk;
  logic rst;
  int   fail_count;
  int   digests_pending;
  int   digest_words_seen;
  int   idle_pct;
  int   stall_pct;
  int   words_sent;
  int   msgs_sent;
  int   quiet_cycles;

  b2s_in_if  msg_ch ();
  b2s_out_if dig_ch ();

  blake2s_256_hash_core DUT (
    .clk(clk),
    .rst(rst),
    .msg(msg_ch),
    .dig(dig_ch)
  );

  b2s_digest_checker checker_i (
    .clk(clk),
    .rst(rst),
    .msg(msg_ch),
    .dig(dig_ch),
    .fail_count(fail_count),
    .digests_pending(digests_pending),
    .digest_words_seen(digest_words_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    dig_ch.ready = ($urandom_range(99) >= stall_pct);
  end

  // no item accepted on either channel for too long
  always @(posedge clk) begin
    if (rst || (msg_ch.valid && msg_ch.ready) || (dig_ch.valid && dig_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("watchdog: no progress for %0d cycles", WatchdogLimit);
        $display("blake2s_256_hash_core_tb NOT OK");
        $finish;
      end
    end
  end

  // drive at the falling edge, hold until accepted
  task automatic send_word(logic [31:0] w, logic [2:0] nb, logic lst);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      msg_ch.valid = 1'b0;
      msg_ch.message_word = $urandom;
      msg_ch.word_bytes = 3'($urandom_range(7));
      msg_ch.last_word = 1'($urandom_range(1));
      @(negedge clk);
    end
    msg_ch.valid = 1'b1;
    msg_ch.message_word = w;
    msg_ch.word_bytes = nb;
    msg_ch.last_word = lst;
    @(posedge clk);
    while (!msg_ch.ready) @(posedge clk);
    words_sent++;
    if (lst) msgs_sent++;
  endtask

  task automatic send_random_msg(int nwords);
    logic [31:0] w;
    for (int i = 0; i < nwords; i++) begin
      case ($urandom_range(9))
        0: w = '0;
        1: w = '1;
        default: w = $urandom;
      endcase
      send_word(w, 3'($urandom_range(7)), (i == nwords - 1));
    end
  endtask

  initial begin
    int len;
    int phase_idle [4] = '{0, 78, 0, 35};
    int phase_stall [4] = '{0, 0, 78, 35};
    rst = 1'b1;
    idle_pct = 0;
    stall_pct = 0;
    words_sent = 0;
    msgs_sent = 0;
    quiet_cycles = 0;
    msg_ch.valid = 1'b0;
    msg_ch.message_word = '0;
    msg_ch.word_bytes = '0;
    msg_ch.last_word = 1'b0;
    dig_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty message, short tails, oversize count, zero-count
    // non-last word, exactly one full block closed by an empty last item
    send_word(32'h0000_0000, 3'd0, 1'b1);
    send_word(32'h0063_6261, 3'd3, 1'b1);
    send_word(32'hFFFF_FFFF, 3'd1, 1'b1);
    send_word(32'hFFFF_FFFF, 3'd7, 1'b1);
    send_word(32'hA5A5_5A5A, 3'd0, 1'b0);
    send_word(32'hFFFF_FFFF, 3'd2, 1'b1);
    for (int i = 0; i < 16; i++) send_word((i[0] ? 32'hFFFF_FFFF : 32'h0), 3'(i % 5), 1'b0);
    send_word(32'h1234_5678, 3'd0, 1'b1);

    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      len = words_sent + 86;
      while (words_sent < len) begin
        case ($urandom_range(9))
          0: send_random_msg($urandom_range(33, 48));
          1: send_random_msg(16 * $urandom_range(1, 2));
          default: send_random_msg($urandom_range(1, 20));
        endcase
      end
    end

    @(negedge clk);
    msg_ch.valid = 1'b0;
    while (digests_pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("sent %0d message words in %0d messages, checked %0d digest words",
             words_sent, msgs_sent, digest_words_seen);
    $display("phases: no idling, sender idle, receiver stall, both");
    if (fail_count == 0) begin
      $display("blake2s_256_hash_core_tb OK");
    end else begin
      $display("blake2s_256_hash_core_tb NOT OK");
    end
    $finish;
  end
endmodule
